>>> rtl/irlrc_pkg.sv
// Package: payload types, register indexes and reset values of the relay controller.
`default_nettype none
package irlrc_pkg;

  localparam int unsigned CfgAddrW = 2;

  typedef enum logic [CfgAddrW-1:0] {
    REG_TEACH_HOLD = 2'd0,
    REG_MIN_PRESS  = 2'd1,
    REG_BLINK_HALF = 2'd2,
    REG_UNUSED     = 2'd3
  } cfg_reg_t;

  localparam logic [15:0] TeachHoldReset = 16'd5000;
  localparam logic [15:0] MinPressReset  = 16'd50;
  localparam logic [15:0] BlinkHalfReset = 16'd250;
  localparam logic [7:0]  ProtErased     = 8'hFF;
  localparam logic [15:0] WordErased     = 16'hFFFF;
  localparam logic [15:0] HoldMax        = 16'hFFFF;

  typedef struct packed {
    logic        button_level;
    logic        frame_valid;
    logic [7:0]  frame_protocol;
    logic [15:0] frame_address;
    logic [15:0] frame_command;
  } in_item_t;

  typedef struct packed {
    logic relay_on;
    logic led_on;
    logic learn_mode;
    logic code_stored;
  } out_item_t;

  typedef struct packed {
    cfg_reg_t    addr;
    logic [15:0] data;
  } cfg_item_t;

endpackage
`default_nettype wire

>>> rtl/irlrc_if.sv
// Interfaces: tick input, result output and configuration write channels.
`default_nettype none
interface irlrc_in_if import irlrc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface irlrc_out_if import irlrc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface irlrc_cfg_if import irlrc_pkg::*; ();
  logic        valid;
  logic        ready;
  cfg_reg_t    addr;
  logic [15:0] data;
  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/ir_learn_relay_controller.sv
// Top level: infrared learning relay controller with two-entry result buffer.
// One input transaction per millisecond tick gives exactly one result transaction. All
// per-tick work is a single pass of logic from the stored state to the next state, so
// a tick is accepted every clock cycle while in_ch.ready is high. The result side holds
// up to two transactions (output register plus skid register); in_ch.ready drops only
// while both are occupied. The configuration port is always ready and takes effect on
// the next tick. The learned code resets to all ones.
`default_nettype none
module ir_learn_relay_controller import irlrc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  irlrc_in_if.sink    in_ch,
  irlrc_out_if.source out_ch,
  irlrc_cfg_if.sink   cfg_ch
);

  logic [15:0] teach_hold_r, min_press_r, blink_half_r;
  logic        prev_button_r, learning_r, relay_level_r, led_level_r, blink_phase_r;
  logic [15:0] hold_count_r, blink_count_r;
  logic [7:0]  saved_prot_r;
  logic [15:0] saved_addr_r, saved_cmd_r;

  out_item_t   out_r, skid_r;
  logic        out_valid_r, skid_valid_r;

  logic        in_fire, out_fire;
  in_item_t    it;

  logic        press_edge, release_edge, toggle, code_match;
  logic        learning_a, learning_nxt, relay_nxt, led_nxt, phase_nxt, stored;
  logic [15:0] hold_nxt, blink_nxt, half;
  logic [16:0] blink_inc;
  out_item_t   res;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = ~skid_valid_r;
  assign in_fire      = in_ch.valid & in_ch.ready;
  assign out_fire     = out_valid_r & out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;
  assign it           = in_ch.data;

  always_comb begin
    press_edge   = prev_button_r & ~it.button_level;
    release_edge = ~prev_button_r & it.button_level;
    if (press_edge) begin
      hold_nxt = '0;
    end else if (hold_count_r != HoldMax) begin
      hold_nxt = hold_count_r + 16'd1;
    end else begin
      hold_nxt = hold_count_r;
    end

    learning_a = learning_r | (~it.button_level & (hold_nxt > teach_hold_r));
    toggle     = release_edge & (hold_nxt > min_press_r) & ~learning_a;
    relay_nxt  = relay_level_r ^ toggle;
    led_nxt    = led_level_r ^ toggle;

    learning_nxt = learning_a;
    stored       = 1'b0;
    code_match   = (it.frame_protocol == saved_prot_r) & (it.frame_address == saved_addr_r);
    if (it.frame_valid) begin
      if (learning_a) begin
        learning_nxt = 1'b0;
        stored       = 1'b1;
      end else if (code_match) begin
        relay_nxt = (it.frame_command != saved_cmd_r);
        led_nxt   = (it.frame_command != saved_cmd_r);
      end
    end

    // Zero half period acts as one.
    half      = (blink_half_r == '0) ? 16'd1 : blink_half_r;
    blink_inc = {1'b0, blink_count_r} + 17'd1;
    if (learning_nxt) begin
      res.led_on = led_nxt ^ ~blink_phase_r;
      if (blink_inc >= {1'b0, half}) begin
        blink_nxt = '0;
        phase_nxt = ~blink_phase_r;
      end else begin
        blink_nxt = blink_inc[15:0];
        phase_nxt = blink_phase_r;
      end
    end else begin
      res.led_on = led_nxt;
      blink_nxt  = '0;
      phase_nxt  = 1'b0;
    end
    res.relay_on    = relay_nxt;
    res.learn_mode  = learning_nxt;
    res.code_stored = stored;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      teach_hold_r  <= TeachHoldReset;
      min_press_r   <= MinPressReset;
      blink_half_r  <= BlinkHalfReset;
      prev_button_r <= 1'b0;
      hold_count_r  <= '0;
      learning_r    <= 1'b0;
      relay_level_r <= 1'b0;
      led_level_r   <= 1'b0;
      saved_prot_r  <= ProtErased;
      saved_addr_r  <= WordErased;
      saved_cmd_r   <= WordErased;
      blink_count_r <= '0;
      blink_phase_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.addr)
          REG_TEACH_HOLD: teach_hold_r <= cfg_ch.data;
          REG_MIN_PRESS:  min_press_r  <= cfg_ch.data;
          REG_BLINK_HALF: blink_half_r <= cfg_ch.data;
          default: ;
        endcase
      end
      if (in_fire) begin
        prev_button_r <= it.button_level;
        hold_count_r  <= hold_nxt;
        learning_r    <= learning_nxt;
        relay_level_r <= relay_nxt;
        led_level_r   <= led_nxt;
        blink_count_r <= blink_nxt;
        blink_phase_r <= phase_nxt;
        if (it.frame_valid && learning_a) begin
          saved_prot_r <= it.frame_protocol;
          saved_addr_r <= it.frame_address;
          saved_cmd_r  <= it.frame_command;
        end
      end
    end
  end

  // Result buffer: output register in front, skid register behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_fire) begin
        out_r <= res;
      end
    end else if (in_fire) begin
      skid_r <= res;
    end
  end

endmodule
`default_nettype wire

>>> rtl/irlrc_checker.sv
// Checker: port-level properties of the relay controller, bound to the top level.
`default_nettype none
module irlrc_checker import irlrc_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // Relay and LED move together except for the learn mode blink.
  a_led_follows_relay: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.learn_mode) |-> (out_data.led_on == out_data.relay_on))
    else $error("led_on differs from relay_on outside learn mode");

  // Storing a code ends learn mode on the same tick.
  a_stored_ends_learn: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.code_stored) |-> !out_data.learn_mode)
    else $error("code_stored with learn_mode still set");

  // Input backpressure only while a result is pending.
  a_ready_low_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in ready low with no result pending");

  // An accepted tick always leaves a result pending on the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted tick produced no result");

  // A stalled result holds.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind ir_learn_relay_controller irlrc_checker u_irlrc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
`default_nettype wire
